/* src/assert_macros.svh */
// Assertion macros for the checker module of this block.
// Both expect a signal named clk, and MP2A_ASSERT one named rst_n, in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while reset is released.
`define MP2A_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");

// Property checked on every rising edge, reset included.
`define MP2A_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

/* src/mp2a_pkg.sv */
`default_nettype none

package mp2a_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int INDEX_W    = 20;
  localparam int COORD_W    = 10;
  localparam int OUT_W      = SAMPLE_W + INDEX_W + 2 * COORD_W;
  localparam int KREG_W     = 4;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [KREG_W-1:0] KERNEL_RST = 4'd2;
  localparam logic [KREG_W-1:0] STRIDE_RST = 4'd0;
  localparam logic [DIM_W-1:0]  DIM_RST    = 11'd1024;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL = 2'd0,
    CFG_STRIDE = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_WIDTH  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_COL,
    ST_DIV_ROW,
    ST_SCAN,
    ST_INDEX
  } state_t;

  // Write control of the line store: all writes every bank at once.
  typedef struct packed {
    logic en;
    logic all;
  } store_wr_t;

endpackage

`default_nettype wire

/* src/mp2a_line_store.sv */
`default_nettype none

module mp2a_line_store import mp2a_pkg::*; #(
  parameter int NBANK = 8,
  parameter int DEPTH = 1024,
  localparam int BW = (NBANK > 1) ? $clog2(NBANK) : 1,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic      clk,
  input  wire store_wr_t wr,
  input  wire logic [BW-1:0] wr_bank,
  input  wire logic [AW-1:0] wr_addr,
  input  wire sample_t   wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output sample_t        rd_data [NBANK]
);

  // One bank per row of the window; every bank is read at the same column.
  sample_t mem [NBANK][DEPTH];

  always_ff @(posedge clk) begin
    for (int b = 0; b < NBANK; b++) begin
      if (wr.en && (wr.all || wr_bank == BW'(b))) begin
        mem[b][wr_addr] <= wr_data;
      end
      rd_data[b] <= mem[b][rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/max_pool_2d_argmax_top.sv */
// Flow: a sample in the first K-1 rows or columns of the plane is taken with ready high and closes no window.
// Otherwise divide passes test the column, then the
// row, against the stride; an off-grid sample returns to idle after the pass that fails.
// A full window: two passes, the scan, then the index state (held while the output register
// still holds an unaccepted word); no new sample is taken until the block is back in idle.
// Reset (synchronous, rst_n low): counters zero, registers to defaults, then the line store is cleared.
`default_nettype none

module max_pool_2d_argmax_top import mp2a_pkg::*; #(
  parameter int MAX_KERNEL = 8,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [SAMPLE_W-1:0]   in_tdata,   // sample
  input  wire logic                  in_tuser,   // plane_start
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_W-1:0]           out_tdata,  // max_value, max_index, out_row, out_col
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int KW  = $clog2(MAX_KERNEL + 1);
  localparam int SW  = (KW > KREG_W) ? KW : KREG_W;
  localparam int BW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int WCW = (WW > DIM_W) ? WW : DIM_W;
  localparam int HCW = (HW > DIM_W) ? HW : DIM_W;
  localparam int RXW = (HW > SW) ? HW : SW;
  localparam int CXW = (WW > SW) ? WW : SW;
  localparam int DVW = (RW > CW) ? RW : CW;
  localparam int DCW = $clog2(DVW);
  localparam int PW  = RW + WW;

  // Configuration registers.
  logic [KREG_W-1:0] kreg_r, sreg_r;
  logic [DIM_W-1:0]  hreg_r, wreg_r;

  logic [SW-1:0]  k_raw;
  logic [KW-1:0]  k_eff;
  logic [SW-1:0]  s_eff;
  logic [HCW-1:0] h_raw;
  logic [HW-1:0]  h_eff;
  logic [WCW-1:0] w_raw;
  logic [WW-1:0]  w_eff;

  assign k_raw = SW'(kreg_r);
  assign k_eff = (k_raw == '0) ? KW'(1) :
                 (k_raw > SW'(MAX_KERNEL)) ? KW'(MAX_KERNEL) : KW'(k_raw);
  assign s_eff = (sreg_r == '0) ? SW'(k_eff) : SW'(sreg_r);
  assign h_raw = HCW'(hreg_r);
  assign h_eff = (h_raw == '0) ? HW'(1) :
                 (h_raw > HCW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(h_raw);
  assign w_raw = WCW'(wreg_r);
  assign w_eff = (w_raw == '0) ? WW'(1) :
                 (w_raw > WCW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_raw);

  // Control and datapath registers.
  state_t          state_r, state_nxt;
  logic [CW-1:0]   clr_addr_r;
  logic [CW-1:0]   col_count_r;
  logic [RW-1:0]   row_count_r;
  logic [BW-1:0]   bank_count_r;
  logic [DVW-1:0]  dvd_r;
  logic [SW-1:0]   rem_r;
  logic [DCW-1:0]  div_cnt_r;
  logic [RW-1:0]   r0_r;
  logic [CW-1:0]   c0_r;
  logic [BW-1:0]   b0_r;
  logic [DVW-1:0]  qc_r, qr_r;
  logic [KW-1:0]   scan_iss_r;
  logic            rd_vld_r;
  logic [KW-1:0]   rd_dc_r;
  sample_t         best_val_r;
  logic [BW-1:0]   best_dr_r;
  logic [KW-1:0]   best_dc_r;
  logic            out_vld_r;
  logic [OUT_W-1:0] out_data_r;

  function automatic logic [BW-1:0] bank_inc(input logic [BW-1:0] b);
    return (b == BW'(MAX_KERNEL - 1)) ? '0 : b + 1'b1;
  endfunction

  logic in_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Position of the incoming sample and the counters after it.
  logic [WW-1:0]  col_t, col_n;
  logic [HW-1:0]  row_t, row_n;
  logic [BW-1:0]  bank_t, bank_n;
  logic [CW-1:0]  col_a;
  logic [RW-1:0]  row_a;
  logic [BW-1:0]  bank_a;

  always_comb begin
    col_t  = in_tuser ? '0 : WW'(col_count_r);
    row_t  = in_tuser ? '0 : HW'(row_count_r);
    bank_t = in_tuser ? '0 : bank_count_r;
    if (col_t >= w_eff) begin
      col_t  = '0;
      row_t  = row_t + 1'b1;
      bank_t = bank_inc(bank_t);
    end
    if (row_t >= h_eff) begin
      row_t  = '0;
      bank_t = '0;
    end
    col_a  = CW'(col_t);
    row_a  = RW'(row_t);
    bank_a = bank_t;

    col_n  = WW'(col_a) + 1'b1;
    row_n  = HW'(row_a);
    bank_n = bank_a;
    if (col_n >= w_eff) begin
      col_n  = '0;
      row_n  = row_n + 1'b1;
      bank_n = bank_inc(bank_n);
      if (row_n >= h_eff) begin
        row_n  = '0;
        bank_n = '0;
      end
    end
  end

  // Does this sample close a window whose corner lies on or past the kernel edge?
  logic [RXW-1:0] row_p1;
  logic [CXW-1:0] col_p1;
  logic           hit;
  logic [RW-1:0]  r0_a;
  logic [CW-1:0]  c0_a;
  logic [BW:0]    b0_sum;
  logic [BW-1:0]  b0_a;

  assign row_p1 = RXW'(row_a) + RXW'(1);
  assign col_p1 = CXW'(col_a) + CXW'(1);
  assign hit    = (row_p1 >= RXW'(k_eff)) && (col_p1 >= CXW'(k_eff));
  assign r0_a   = RW'(row_p1 - RXW'(k_eff));
  assign c0_a   = CW'(col_p1 - CXW'(k_eff));

  // Bank of the window's top row: current bank minus K-1, modulo bank count.
  always_comb begin
    b0_sum = (BW+1)'(bank_a) + (BW+1)'(MAX_KERNEL) - (BW+1)'(k_eff) + (BW+1)'(1);
    if (b0_sum >= (BW+1)'(MAX_KERNEL)) begin
      b0_sum = b0_sum - (BW+1)'(MAX_KERNEL);
    end
    b0_a = BW'(b0_sum);
  end

  // Shared restoring divider, one quotient bit per cycle.
  logic [SW:0]    trial;
  logic           q_bit;
  logic [SW-1:0]  rem_new;
  logic [DVW-1:0] dvd_new;
  logic           div_last;

  assign trial    = {rem_r, dvd_r[DVW-1]};
  assign q_bit    = (trial >= (SW+1)'(s_eff));
  assign rem_new  = q_bit ? SW'(trial - (SW+1)'(s_eff)) : SW'(trial);
  assign dvd_new  = {dvd_r[DVW-2:0], q_bit};
  assign div_last = (div_cnt_r == DCW'(DVW - 1));

  // Line store.
  store_wr_t      st_wr;
  logic [CW-1:0]  st_wr_addr;
  sample_t        st_wr_data;
  logic [CW-1:0]  st_rd_addr;
  sample_t        rd_data [MAX_KERNEL];
  logic           issue;

  assign st_wr.en    = in_acc || (state_r == ST_CLEAR);
  assign st_wr.all   = (state_r == ST_CLEAR);
  assign st_wr_addr  = (state_r == ST_CLEAR) ? clr_addr_r : col_a;
  assign st_wr_data  = (state_r == ST_CLEAR) ? sample_t'(0) : sample_t'(in_tdata);
  assign issue       = (state_r == ST_SCAN) && (scan_iss_r < k_eff);
  assign st_rd_addr  = c0_r + CW'(scan_iss_r);

  mp2a_line_store #(
    .NBANK (MAX_KERNEL),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr      (st_wr),
    .wr_bank (bank_a),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr),
    .rd_data (rd_data)
  );

  // Column compare: rotate banks into window-row order, take the column maximum
  // (lowest row on ties), then merge with the running best in row-major order.
  sample_t        row_val [MAX_KERNEL];
  sample_t        col_best;
  logic [BW-1:0]  col_dr;
  logic [BW:0]    bsel;
  logic           take;
  logic           scan_done;

  always_comb begin
    for (int dr = 0; dr < MAX_KERNEL; dr++) begin
      bsel = (BW+1)'(b0_r) + (BW+1)'(dr);
      if (bsel >= (BW+1)'(MAX_KERNEL)) begin
        bsel = bsel - (BW+1)'(MAX_KERNEL);
      end
      row_val[dr] = rd_data[BW'(bsel)];
    end
    col_best = row_val[0];
    col_dr   = '0;
    for (int dr = 1; dr < MAX_KERNEL; dr++) begin
      if ((KW'(dr) < k_eff) && (row_val[dr] > col_best)) begin
        col_best = row_val[dr];
        col_dr   = BW'(dr);
      end
    end
    take = (rd_dc_r == '0) || (col_best > best_val_r) ||
           ((col_best == best_val_r) && (col_dr < best_dr_r));
  end

  assign scan_done = rd_vld_r && (rd_dc_r == KW'(k_eff - 1'b1));

  // In-plane index of the maximum.
  logic [RW-1:0] best_row;
  logic [CW-1:0] best_col;
  logic [PW-1:0] idx_sum;
  logic          out_free;

  assign best_row = r0_r + RW'(best_dr_r);
  assign best_col = c0_r + CW'(best_dc_r);
  assign idx_sum  = PW'(best_row) * PW'(w_eff) + PW'(best_col);
  assign out_free = !out_vld_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == CW'(MAX_WIDTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc && hit) state_nxt = ST_DIV_COL;
      end
      ST_DIV_COL: begin
        if (div_last) state_nxt = (rem_new != '0) ? ST_IDLE : ST_DIV_ROW;
      end
      ST_DIV_ROW: begin
        if (div_last) state_nxt = (rem_new != '0) ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = ST_INDEX;
      end
      ST_INDEX: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      col_count_r  <= '0;
      row_count_r  <= '0;
      bank_count_r <= '0;
      kreg_r       <= KERNEL_RST;
      sreg_r       <= STRIDE_RST;
      hreg_r       <= DIM_RST;
      wreg_r       <= DIM_RST;
      div_cnt_r    <= '0;
      scan_iss_r   <= '0;
      rd_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_KERNEL: kreg_r <= cfg_wdata[KREG_W-1:0];
          CFG_STRIDE: sreg_r <= cfg_wdata[KREG_W-1:0];
          CFG_HEIGHT: hreg_r <= cfg_wdata;
          CFG_WIDTH:  wreg_r <= cfg_wdata;
        endcase
      end
      if (in_acc) begin
        col_count_r  <= CW'(col_n);
        row_count_r  <= RW'(row_n);
        bank_count_r <= bank_n;
      end
      if ((state_r == ST_DIV_COL) || (state_r == ST_DIV_ROW)) begin
        div_cnt_r <= div_last ? '0 : div_cnt_r + 1'b1;
      end else begin
        div_cnt_r <= '0;
      end
      if (state_r == ST_DIV_ROW) begin
        scan_iss_r <= '0;
      end else if (issue) begin
        scan_iss_r <= scan_iss_r + 1'b1;
      end
      rd_vld_r <= issue;
      if ((state_r == ST_INDEX) && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      r0_r  <= r0_a;
      c0_r  <= c0_a;
      b0_r  <= b0_a;
      dvd_r <= DVW'(c0_a);
      rem_r <= '0;
    end else if ((state_r == ST_DIV_COL) && div_last) begin
      qc_r  <= dvd_new;
      dvd_r <= DVW'(r0_r);
      rem_r <= '0;
    end else if ((state_r == ST_DIV_ROW) && div_last) begin
      qr_r  <= dvd_new;
    end else if ((state_r == ST_DIV_COL) || (state_r == ST_DIV_ROW)) begin
      dvd_r <= dvd_new;
      rem_r <= rem_new;
    end
    rd_dc_r <= scan_iss_r;
    if (rd_vld_r && take) begin
      best_val_r <= col_best;
      best_dr_r  <= col_dr;
      best_dc_r  <= rd_dc_r;
    end
    if ((state_r == ST_INDEX) && out_free) begin
      out_data_r <= {COORD_W'(qc_r), COORD_W'(qr_r), INDEX_W'(idx_sum), best_val_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* src/mp2a_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module mp2a_checker import mp2a_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  // A stalled result word keeps its value.
  `MP2A_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // The block only goes busy because it took a word.
  `MP2A_ASSERT(a_busy_cause, $fell(in_tready) && $past(rst_n) |-> $past(in_tvalid))

  // A new result appears only at the end of a window scan, while input is held off.
  `MP2A_ASSERT(a_result_busy, $rose(out_tvalid) |-> $past(!in_tready))

  // The cycle after a reset edge nothing is offered and the line store is being cleared.
  `MP2A_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid && !in_tready)

endmodule

bind max_pool_2d_argmax_top mp2a_checker u_mp2a_checker (.*);

`default_nettype wire

/* dv/pool_argmax_checker.sv */
module pool_argmax_checker import mp2a_pkg::*; #(
  parameter int MAX_KERNEL = 8,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,   // sample
  input  logic                  in_tuser,   // plane_start
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_W-1:0]      out_tdata,  // max_value, max_index, out_row, out_col
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Field order follows out_tdata from the top bit down.
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [INDEX_W-1:0] index;
    sample_t            value;
  } pool_word_t;

  sample_t           rows_held [MAX_KERNEL*MAX_WIDTH];
  logic [KREG_W-1:0] kernel_reg;
  logic [KREG_W-1:0] stride_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [DIM_W-1:0]  width_reg;
  int unsigned       row_pos;
  int unsigned       col_pos;
  pool_word_t        window_q [$];
  int                reported;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned top);
    return (v == 0) ? 1 : ((v > top) ? top : v);
  endfunction

  function automatic int unsigned slot(int unsigned r, int unsigned c);
    return (r % MAX_KERNEL) * MAX_WIDTH + (c % MAX_WIDTH);
  endfunction

  // Places one sample in the line store and, when it closes a window,
  // queues the window's maximum and where it sits.
  task automatic take_sample(sample_t x, logic start);
    int unsigned k, s, h, w, row, col, r0, c0, best_r, best_c, dr, dc;
    sample_t     best;
    pool_word_t  word;
    k = clamp_dim(kernel_reg, MAX_KERNEL);
    s = (stride_reg == 0) ? k : stride_reg;
    h = clamp_dim(height_reg, MAX_HEIGHT);
    w = clamp_dim(width_reg, MAX_WIDTH);
    if (start) begin
      row_pos = 0;
      col_pos = 0;
    end
    // Dimensions may have shrunk below the counters since the last sample.
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    row = row_pos;
    col = col_pos;
    rows_held[slot(row, col)] = x;
    if (row + 1 >= k && col + 1 >= k &&
        (row + 1 - k) % s == 0 && (col + 1 - k) % s == 0) begin
      r0 = row + 1 - k;
      c0 = col + 1 - k;
      best = rows_held[slot(r0, c0)];
      best_r = r0;
      best_c = c0;
      // Strictly greater only, so a tie keeps the earliest element.
      for (dr = 0; dr < k; dr++) begin
        for (dc = 0; dc < k; dc++) begin
          if (rows_held[slot(r0 + dr, c0 + dc)] > best) begin
            best = rows_held[slot(r0 + dr, c0 + dc)];
            best_r = r0 + dr;
            best_c = c0 + dc;
          end
        end
      end
      word.value = best;
      word.index = INDEX_W'(best_r * w + best_c);
      word.row = COORD_W'(r0 / s);
      word.col = COORD_W'(c0 / s);
      window_q.push_back(word);
    end
    col_pos = col + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  always @(posedge clk) begin
    pool_word_t got;
    pool_word_t want;
    if (!rst_n) begin
      foreach (rows_held[i]) rows_held[i] = '0;
      kernel_reg = KERNEL_RST;
      stride_reg = STRIDE_RST;
      height_reg = DIM_RST;
      width_reg = DIM_RST;
      row_pos = 0;
      col_pos = 0;
      window_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (window_q.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            reported++;
            $display("%0t: unexpected word value %0d index %0d row %0d col %0d",
                     $realtime, got.value, got.index, got.row, got.col);
          end
        end else begin
          want = window_q.pop_front();
          if (got.value != want.value || got.index != want.index ||
              got.row != want.row || got.col != want.col) begin
            fail_count++;
            if (reported < 10) begin
              reported++;
              $display("%0t: mismatch value %0d/%0d index %0d/%0d row %0d/%0d col %0d/%0d",
                       $realtime, want.value, got.value, want.index, got.index,
                       want.row, got.row, want.col, got.col);
            end
          end
        end
      end
      if (in_tvalid && in_tready) take_sample(sample_t'(in_tdata), in_tuser);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_KERNEL: kernel_reg = cfg_wdata[KREG_W-1:0];
          CFG_STRIDE: stride_reg = cfg_wdata[KREG_W-1:0];
          CFG_HEIGHT: height_reg = cfg_wdata[DIM_W-1:0];
          CFG_WIDTH:  width_reg = cfg_wdata[DIM_W-1:0];
          default: ;
        endcase
      end
    end
    pending = window_q.size();
  end

endmodule

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mp2a_pkg::*;

  localparam int TOTAL_ITEMS   = 1700;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES   = 300;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata = '0;   // sample
  logic                  in_tuser = 1'b0; // plane_start
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;       // max_value, max_index, out_row, out_col
  logic                  cfg_we = 1'b0;
  cfg_reg_t              cfg_index = CFG_KERNEL;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int sent;
  int cycle_count;
  bit calm;
  bit hold_req;

  max_pool_2d_argmax_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  pool_argmax_checker window_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial forever #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t which, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_word(sample_t value, logic start);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    in_tuser <= start;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
  endtask

  // Waits until every queued window has come out, then lets the block
  // finish any divide pass of a sample that closed no window.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? sample_t'(16'h7fff) : sample_t'(16'h8000);
      1, 2: return sample_t'(int'($urandom_range(0, 4)) - 2);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(1025, 2047);
      2: return 1024;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  initial begin
    int gap;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 6);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      // A stall starts only once a word is actually waiting.
      if (gap != 0) begin
        out_tready <= 1'b0;
        do @(posedge clk); while (!out_tvalid);
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    sample_t     grid [16];
    int unsigned v;
    int          burst;
    int          phase;
    bit          fresh;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // The line store is cleared after reset; ready rises when that is done.
    do @(posedge clk); while (!in_tready);
    @(negedge clk);

    // 4x4 plane, 2x2 windows: all-minimum window, maximum in the last slot,
    // and two more windows whose maximum appears twice or more.
    write_reg(CFG_HEIGHT, 4);
    write_reg(CFG_WIDTH, 4);
    write_reg(CFG_KERNEL, 2);
    write_reg(CFG_STRIDE, 0);
    grid = '{-32768, -32768, 0, 5, -32768, -32768, 5, 32767,
             7, -1, -1, -2, 3, 7, -1, -1};
    foreach (grid[i]) send_word(grid[i], i == 0);
    settle();

    // Zero kernel and zero height both act as one.
    write_reg(CFG_KERNEL, 0);
    write_reg(CFG_HEIGHT, 0);
    write_reg(CFG_WIDTH, 3);
    send_word(32767, 1'b1);
    send_word(-32768, 1'b0);
    send_word(0, 1'b0);
    settle();

    // Oversized kernel on a 2x2 plane: nothing completes.
    write_reg(CFG_KERNEL, 15);
    write_reg(CFG_WIDTH, 2);
    write_reg(CFG_HEIGHT, 2);
    repeat (4) send_word(pick_sample(), 1'b0);

    phase = 0;
    while (sent < TOTAL_ITEMS) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        // One word per sample while the receiver holds off.
        write_reg(CFG_KERNEL, 1);
        write_reg(CFG_STRIDE, 0);
        write_reg(CFG_HEIGHT, 4);
        write_reg(CFG_WIDTH, 4);
        hold_req = 1'b1;
      end else begin
        if (phase == 0 || $urandom_range(0, 1)) begin
          case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 8;
            2: v = $urandom_range(9, 15);
            default: v = $urandom_range(1, 4);
          endcase
          write_reg(CFG_KERNEL, v);
        end
        if (phase == 0 || $urandom_range(0, 1)) begin
          case ($urandom_range(0, 5))
            0, 1: v = 0;
            2: v = $urandom_range(9, 15);
            default: v = $urandom_range(1, 4);
          endcase
          write_reg(CFG_STRIDE, v);
        end
        if (phase == 0 || $urandom_range(0, 1)) write_reg(CFG_HEIGHT, pick_dim());
        if (phase == 0 || $urandom_range(0, 1)) write_reg(CFG_WIDTH, pick_dim());
      end
      burst = $urandom_range(20, 90);
      fresh = (phase == 3) || ($urandom_range(0, 3) != 0);
      for (int i = 0; i < burst; i++)
        send_word(pick_sample(), (i == 0 && fresh) || ($urandom_range(0, 39) == 0));
      phase++;
    end
    settle();

    if (fail_count == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
